@@ rtl/oer_pkg.sv @@
// oer_pkg: request, result and slot record types, request/status/filter codes
// and the state encoding for the overwriting event ring.
// No dependencies.
package oer_pkg;

   localparam logic [2:0] REQ_PUSH    = 3'd0;
   localparam logic [2:0] REQ_GET     = 3'd1;
   localparam logic [2:0] REQ_LIST    = 3'd2;
   localparam logic [2:0] REQ_RESERVE = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   localparam logic [1:0] FLT_ALL    = 2'd0;
   localparam logic [1:0] FLT_PORT   = 2'd1;
   localparam logic [1:0] FLT_SOURCE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [63:0] event_id;
      logic [63:0] port_key;
      logic [63:0] source_key;
      logic [63:0] payload;
      logic [1:0]  filter_mode;
      logic [4:0]  list_limit;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        has_event;
      logic [63:0] out_id;
      logic [63:0] out_port;
      logic [63:0] out_source;
      logic [63:0] out_payload;
      logic [4:0]  match_count;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] id;
      logic [63:0] port;
      logic [63:0] source;
      logic [63:0] payload;
   } slot_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // result item carrying a stored record
   function automatic rsp_item_type rsp_of_slot(slot_type s);
      rsp_item_type r;
      r             = '0;
      r.status      = ST_OK;
      r.has_event   = 1'b1;
      r.out_id      = s.id;
      r.out_port    = s.port;
      r.out_source  = s.source;
      r.out_payload = s.payload;
      return r;
   endfunction

endpackage

@@ rtl/overwriting_event_ring_with_search.sv @@
// Overwriting event ring with search: slot memory, scan sequencer, result register.
// Depends on oer_pkg.
//
// Push, reserve, clear, rejected and trivially answered requests give their
//   single result in the cycle after accept. Get and list scan the stored entries
//   through the single memory read port, one slot per cycle; busy holds for the
//   whole scan, so no new request is taken until the scan ends.
// Reset: capacity DEPTH, ring empty, next id 1; slot memory is not cleared.
// Results are single-cycle strobes on rsp_valid; the receiver cannot stall.
module overwriting_event_ring_with_search
   import oer_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // (base + off) mod cap, with base < cap and off < cap
   function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [CW-1:0] off,
                                             logic [CW-1:0] cap);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(cap)) begin
         sum = sum - (CW+1)'(cap);
      end
      return AW'(sum);
   endfunction

   slot_type mem [DEPTH];

   state_type    state_ff, state_in;
   req_item_type req_ff, req_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [63:0]  next_id_ff, next_id_in;
   logic [CW-1:0] off_ff, off_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic         rd_valid_ff, rd_valid_in;
   slot_type     rd_data_ff;
   slot_type     pend_ff, pend_in;
   logic         pend_valid_ff, pend_valid_in;
   logic [4:0]   n_ff, n_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          hit;
   logic [4:0]    n_inc;
   logic          csr_ok;
   logic          filter_bad;
   logic [63:0]   id_inc;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      cap_in        = cap_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      next_id_in    = next_id_ff;
      off_in        = off_ff;
      rem_in        = rem_ff;
      rd_valid_in   = 1'b0;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      n_in          = n_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      wr_addr       = head_ff;

      rd_addr = slot_of(head_ff, off_ff, cap_ff);
      n_inc   = n_ff + 5'd1;
      id_inc  = next_id_ff + 64'd1;
      csr_ok  = (csr_wdata != 5'd0) && (int'(csr_wdata) <= DEPTH);

      case (req_ff.req_type)
         REQ_GET: hit = (rd_data_ff.id == req_ff.event_id);
         default: begin
            case (req_ff.filter_mode)
               FLT_PORT:   hit = (rd_data_ff.port == req_ff.port_key);
               FLT_SOURCE: hit = (rd_data_ff.source == req_ff.source_key);
               default:    hit = 1'b1;
            endcase
         end
      endcase

      filter_bad = !((req_item.filter_mode == FLT_ALL) ||
                     ((req_item.filter_mode == FLT_PORT) && (req_item.port_key != 64'd0)) ||
                     ((req_item.filter_mode == FLT_SOURCE) && (req_item.source_key != 64'd0)));

      case (state_ff)
         S_IDLE: begin
            if (csr_we && csr_ok) begin
               cap_in     = CW'(csr_wdata);
               head_in    = '0;
               fill_in    = '0;
               next_id_in = 64'd1;
            end else if (start) begin
               req_in       = req_item;
               rsp_in.last  = 1'b1;
               rsp_in.status = ST_OK;
               case (req_item.req_type)
                  REQ_PUSH: begin
                     rsp_valid_in = 1'b1;
                     mem_we       = 1'b1;
                     if (fill_ff < cap_ff) begin
                        wr_addr = slot_of(head_ff, fill_ff, cap_ff);
                        fill_in = fill_ff + CW'(1);
                     end else begin
                        // full: overwrite the oldest entry
                        wr_addr = head_ff;
                        head_in = slot_of(head_ff, CW'(1), cap_ff);
                     end
                  end
                  REQ_GET: begin
                     if ((req_item.event_id == 64'd0) || (fill_ff == '0)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_NOT_FOUND;
                     end else begin
                        off_in   = '0;
                        rem_in   = fill_ff;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_LIST: begin
                     if (filter_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_INVALID;
                     end else if ((req_item.list_limit == 5'd0) || (fill_ff == '0)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        // newest first
                        off_in        = fill_ff - CW'(1);
                        rem_in        = fill_ff;
                        n_in          = 5'd0;
                        pend_valid_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  REQ_RESERVE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.out_id = next_id_ff;
                     next_id_in    = (id_inc == 64'd0) ? 64'd1 : id_inc;
                  end
                  REQ_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     head_in      = '0;
                     fill_in      = '0;
                     next_id_in   = 64'd1;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_INVALID;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read a cycle, check the previous one's data
            if (rem_ff != '0) begin
               rd_valid_in = 1'b1;
               rem_in      = rem_ff - CW'(1);
               off_in      = (req_ff.req_type == REQ_GET) ? off_ff + CW'(1) : off_ff - CW'(1);
            end
            if (req_ff.req_type == REQ_GET) begin
               if (rd_valid_ff && hit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = rsp_of_slot(rd_data_ff);
                  rsp_in.last  = 1'b1;
                  rd_valid_in  = 1'b0;
                  state_in     = S_IDLE;
               end else if (rem_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_NOT_FOUND;
                  rsp_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               // a match is held back in pend until the next match or the finish, so the final one can carry last
               if (rd_valid_ff && hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = rsp_of_slot(pend_ff);
                  end
                  pend_in       = rd_data_ff;
                  pend_valid_in = 1'b1;
                  n_in          = n_inc;
                  if (n_inc == req_ff.list_limit) begin
                     rd_valid_in = 1'b0;
                     state_in    = S_FINISH;
                  end
               end
               if (rem_ff == '0) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_in             = rsp_of_slot(pend_ff);
               rsp_in.match_count = n_ff;
            end else begin
               rsp_in.status = ST_OK;
            end
            rsp_in.last   = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cap_ff        <= CW'(DEPTH);
         head_ff       <= '0;
         fill_ff       <= '0;
         next_id_ff    <= 64'd1;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         next_id_ff    <= next_id_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      off_ff  <= off_in;
      rem_ff  <= rem_in;
      pend_ff <= pend_in;
      n_ff    <= n_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= '{id: req_item.event_id, port: req_item.port_key,
                           source: req_item.source_key, payload: req_item.payload};
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill count exceeds capacity");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      CW'(head_ff) < cap_ff)
      else $error("head pointer outside capacity");

   a_count_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> rsp_item.match_count == 5'd0)
      else $error("match count on a non-final result");

   a_simple_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !csr_we && req_item.req_type != REQ_GET
         && req_item.req_type != REQ_LIST |=> rsp_valid && rsp_item.last && !busy)
      else $error("single-cycle request not answered next cycle");

endmodule
